// ===== hw/rtl/gnpc_pkg.sv =====
package gnpc_pkg;

   localparam int DIM_W      = 8;
   localparam int PIECE_W    = 6;
   localparam int COUNT_W    = 64;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LIST,
      ST_XFETCH,
      ST_XLOAD,
      ST_YRUN,
      ST_YDRAIN,
      ST_WRITE,
      ST_SUMRUN,
      ST_SUMDRAIN,
      ST_DONE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic list_step;
      logic x_load;
      logic y_issue;
      logic cell_write;
      logic sum_issue;
      logic result_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic size_err;
      logic empty;
      logic list_last;
      logic skip;
      logic y_last;
      logic x_last;
      logic j_last;
      logic row_last;
   } status_type;

endpackage

// ===== hw/rtl/gnpc_ctrl.sv =====
module gnpc_ctrl
   import gnpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.size_err || status.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LIST;
            end
         end
         ST_LIST: begin
            cmd.list_step = 1'b1;
            if (status.list_last) begin
               state_in = ST_XFETCH;
            end
         end
         ST_XFETCH: begin
            state_in = ST_XLOAD;
         end
         ST_XLOAD: begin
            cmd.x_load = 1'b1;
            state_in   = status.skip ? ST_WRITE : ST_YRUN;
         end
         ST_YRUN: begin
            cmd.y_issue = 1'b1;
            if (status.y_last) begin
               state_in = ST_YDRAIN;
            end
         end
         ST_YDRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.cell_write = 1'b1;
            if (status.x_last && status.j_last && status.row_last) begin
               state_in = ST_SUMRUN;
            end else begin
               state_in = ST_XFETCH;
            end
         end
         ST_SUMRUN: begin
            cmd.sum_issue = 1'b1;
            if (status.y_last) begin
               state_in = ST_SUMDRAIN;
            end
         end
         ST_SUMDRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hw/rtl/gnpc_dp.sv =====
module gnpc_dp
   import gnpc_pkg::*;
#(
   parameter int MASK_BITS  = 8,
   parameter int MAX_ROWS   = 128,
   parameter int MAX_PIECES = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int MW  = MASK_BITS;
   localparam int PW  = $clog2(MAX_PIECES + 1);
   localparam int JW  = (PW > PIECE_W) ? PW : PIECE_W;
   localparam int AW  = 1 + PW + MW;
   localparam int TW  = MW + 1;

   // mask list and two DP rows
   logic [MW-1:0]      mask_mem [2**MW];
   logic [COUNT_W-1:0] tab_mem  [2**AW];

   logic [DIM_W-1:0]   w_ff, h_ff, row_ff;
   logic [JW-1:0]      k_ff, j_ff, px_ff;
   logic [TW-1:0]      m_ff, total_ff;
   logic [MW-1:0]      x_ff, y_ff, mx_ff, mask_q_ff;
   logic               cur_ff;
   logic [COUNT_W-1:0] acc_ff, tab_q_ff;
   logic               valid_q_ff, sum_q_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_err_ff;

   logic [DIM_W-1:0]   in_rows, in_cols;
   logic [PIECE_W-1:0] in_pieces;
   logic [MW-1:0]      m_low;
   logic               m_ok;
   logic [JW-1:0]      pop_q;
   logic [JW-1:0]      j_minus_px;
   logic [MW-1:0]      mask_addr;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [COUNT_W-1:0] wr_data, term;
   logic               first_row;

   assign in_rows   = req_tdata[7:0];
   assign in_cols   = req_tdata[15:8];
   assign in_pieces = req_tdata[21:16];

   assign m_low = m_ff[MW-1:0];
   assign m_ok  = ((m_low & (m_low << 1)) == '0);

   always_comb begin
      pop_q = '0;
      for (int b = 0; b < MW; b++) begin
         pop_q = pop_q + JW'(mask_q_ff[b]);
      end
   end

   assign first_row  = (row_ff == DIM_W'(1));
   assign j_minus_px = j_ff - px_ff;
   assign mask_addr  = cmd.y_issue ? y_ff : x_ff;

   always_comb begin
      if (cmd.sum_issue) begin
         rd_addr = {cur_ff, k_ff[PW-1:0], y_ff};
      end else begin
         rd_addr = {cur_ff, j_minus_px[PW-1:0], y_ff};
      end
   end

   assign wr_addr = {~cur_ff, j_ff[PW-1:0], x_ff};

   always_comb begin
      if (first_row) begin
         wr_data = (px_ff == j_ff) ? COUNT_W'(1) : '0;
      end else if (px_ff > j_ff) begin
         wr_data = '0;
      end else begin
         wr_data = acc_ff;
      end
   end

   // drop terms whose mask collides with the current row mask, except in the final sum
   assign term = (sum_q_ff || ((mx_ff & mask_q_ff) == '0)) ? tab_q_ff : '0;

   always_comb begin
      status.size_err  = (32'(w_ff) > MASK_BITS) || (32'(h_ff) > MAX_ROWS) ||
                         (32'(k_ff) > MAX_PIECES);
      status.empty     = (w_ff == '0);
      status.list_last = (m_ff == TW'((32'd1 << w_ff) - 32'd1));
      status.skip      = first_row || (pop_q > j_ff);
      status.y_last    = ({1'b0, y_ff} == total_ff - TW'(1));
      status.x_last    = ({1'b0, x_ff} == total_ff - TW'(1));
      status.j_last    = (j_ff == k_ff);
      status.row_last  = (row_ff == h_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.list_step && m_ok) begin
         mask_mem[total_ff[MW-1:0]] <= m_low;
      end
      mask_q_ff <= mask_mem[mask_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.cell_write) begin
         tab_mem[wr_addr] <= wr_data;
      end
      tab_q_ff <= tab_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_q_ff <= 1'b0;
         sum_q_ff   <= 1'b0;
      end else begin
         valid_q_ff <= cmd.y_issue || cmd.sum_issue;
         sum_q_ff   <= cmd.sum_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff     <= (in_rows < in_cols) ? in_rows : in_cols;
         h_ff     <= (in_rows < in_cols) ? in_cols : in_rows;
         k_ff     <= JW'(in_pieces);
         m_ff     <= '0;
         total_ff <= '0;
         row_ff   <= DIM_W'(1);
         j_ff     <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         cur_ff   <= 1'b1;
         acc_ff   <= '0;
      end else begin
         if (cmd.list_step) begin
            m_ff <= m_ff + TW'(1);
            if (m_ok) begin
               total_ff <= total_ff + TW'(1);
            end
         end
         if (cmd.x_load) begin
            mx_ff  <= mask_q_ff;
            px_ff  <= pop_q;
            y_ff   <= '0;
            acc_ff <= '0;
         end
         if (cmd.y_issue || cmd.sum_issue) begin
            y_ff <= y_ff + MW'(1);
         end
         if (valid_q_ff) begin
            acc_ff <= acc_ff + term;
         end
         if (cmd.cell_write) begin
            y_ff   <= '0;
            acc_ff <= '0;
            if (status.x_last) begin
               x_ff <= '0;
               if (status.j_last) begin
                  j_ff   <= '0;
                  row_ff <= row_ff + DIM_W'(1);
                  cur_ff <= ~cur_ff;
               end else begin
                  j_ff <= j_ff + JW'(1);
               end
            end else begin
               x_ff <= x_ff + MW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         if (status.size_err) begin
            out_count_ff <= '0;
            out_err_ff   <= 1'b1;
         end else if (status.empty) begin
            out_count_ff <= (k_ff == '0) ? COUNT_W'(1) : '0;
            out_err_ff   <= 1'b0;
         end else begin
            out_count_ff <= acc_ff;
            out_err_ff   <= 1'b0;
         end
      end
   end

   assign rsp_tdata = out_count_ff;
   assign rsp_tuser = out_err_ff;

endmodule

// ===== hw/rtl/grid_nonadjacent_placement_count_core.sv =====
// Counts the ways to place exactly piece_total pieces on a board_rows x
// board_cols grid with no two pieces sharing an edge, modulo 2^64. The narrow
// side becomes the row width; the block lists the row masks without adjacent
// bits, then runs a row-by-row DP over (pieces used, row mask) in a two-bank
// table memory. One query is handled at a time. Each table cell costs a mask
// fetch, a mask load, one table read per listed mask, a drain and a write;
// cells of the first row and cells whose mask holds more pieces than the
// cell's count skip the table reads and the drain. The time is set by the
// single table read port that the inner sum walks one entry per cycle over
// all listed masks, dropping those that collide with the cell's mask. A query
// that is too large or has an empty side skips the DP and goes from the check
// straight to the result. The next query is taken while the previous result
// waits in the output register.
module grid_nonadjacent_placement_count_core
   import gnpc_pkg::*;
#(
   parameter int MASK_BITS  = 8,
   parameter int MAX_ROWS   = 128,
   parameter int MAX_PIECES = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // board_rows, board_cols, piece_total
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // way_count
   output logic                  rsp_tuser    // size_error
);

   cmd_type    cmd;
   status_type status;

   gnpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gnpc_dp #(
      .MASK_BITS  (MASK_BITS),
      .MAX_ROWS   (MAX_ROWS),
      .MAX_PIECES (MAX_PIECES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
